/* rtl/assert_macros.svh */
// assertion macros used by the fpa_out module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, clocked on clk, off while rst_n is low
`define FPA_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on clk, off while rst_n is low
`define FPA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/fpa_pkg.sv */
// types, constants and operation codes of the 16.16 fixed-point alu
`default_nettype none

package fpa_pkg;

    localparam int WORD_W     = 32;
    localparam int FRAC_BITS  = 16;
    localparam int INT_W      = WORD_W - FRAC_BITS;
    localparam int MODE_W     = 4;
    localparam int PROD_W     = 2 * WORD_W;
    localparam int DIVIDEND_W = WORD_W + FRAC_BITS;
    localparam int DIV_STEPS  = DIVIDEND_W;

    localparam logic [WORD_W-1:0] ALL_ONES = {WORD_W{1'b1}};

    // operation select codes
    typedef enum logic [MODE_W-1:0] {
        MODE_ADD      = 4'd0,
        MODE_SUB      = 4'd1,
        MODE_MUL      = 4'd2,
        MODE_DIV      = 4'd3,
        MODE_ADD_INT  = 4'd4,
        MODE_SUB_INT  = 4'd5,
        MODE_MUL_INT  = 4'd6,
        MODE_DIV_INT  = 4'd7,
        MODE_FROM_INT = 4'd8,
        MODE_TO_INT   = 4'd9
    } mode_t;

    // restoring divider state carried from step to step
    typedef struct packed {
        logic [WORD_W-1:0]     rem;
        logic [DIVIDEND_W-1:0] num;
        logic [WORD_W-1:0]     divisor;
        logic [WORD_W-1:0]     quo;
    } div_t;

    // result of the non-divide paths plus divide control
    typedef struct packed {
        logic [WORD_W-1:0] value;
        logic              is_div;
        logic              dz;
    } side_t;

    // everything one pipeline stage holds for an item
    typedef struct packed {
        div_t  div;
        side_t side;
    } stage_t;

endpackage

`default_nettype wire

/* rtl/fixed_point_16_16_alu.sv */
// top level of the unsigned 16.16 fixed-point alu pipeline
//
//  channel   dir   signals                       contents
//  s_axis    in    tvalid tready tdata tuser     operands and mode
//  m_axis    out   tvalid tready tdata tuser     result and divide-by-zero flag
//
// one item per cycle while s_axis_tready is high; a result is presented on m_axis after
// the input register, multiply stage, 48 restoring division stages and output slot
// the 48 division stages, one quotient bit each, set the latency
// reset clears the valid bits only; data registers are not reset
// a stalled output holds one result and catches one more in a skid slot,
// then s_axis_tready drops and the whole pipeline holds
`default_nettype none

module fixed_point_16_16_alu
    import fpa_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [63:0]       s_axis_tdata,   // operand_a [31:0], operand_b [63:32]
    input  wire logic [MODE_W-1:0] s_axis_tuser,   // mode [3:0]
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic [WORD_W-1:0]      m_axis_tdata,   // result [31:0]
    output logic [0:0]             m_axis_tuser    // divide_by_zero [0]
);

    logic   en;
    logic   front_valid;
    stage_t front_stage;
    logic   dz;
    logic   valid_chain [0:DIV_STEPS];
    stage_t stage_chain [0:DIV_STEPS];

    // operand registers, decode and multiplier
    fpa_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_axis_tvalid),
        .in_mode   (s_axis_tuser),
        .in_a      (s_axis_tdata[WORD_W-1:0]),
        .in_b      (s_axis_tdata[2*WORD_W-1:WORD_W]),
        .out_valid (front_valid),
        .out_stage (front_stage)
    );

    assign valid_chain[0] = front_valid;
    assign stage_chain[0] = front_stage;

    // division pipeline
    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_div
        fpa_div_stage u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (valid_chain[i]),
            .in_stage  (stage_chain[i]),
            .out_valid (valid_chain[i+1]),
            .out_stage (stage_chain[i+1])
        );
    end

    // result select and output buffer
    fpa_out u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .pipe_valid (valid_chain[DIV_STEPS]),
        .pipe_stage (stage_chain[DIV_STEPS]),
        .ready      (m_axis_tready),
        .en         (en),
        .out_valid  (m_axis_tvalid),
        .out_result (m_axis_tdata),
        .out_dz     (dz)
    );

    assign s_axis_tready   = en;
    assign m_axis_tuser[0] = dz;

endmodule

`default_nettype wire

/* rtl/fpa_front.sv */
// input register, decode, multiplier and divider setup stages
`default_nettype none

module fpa_front
    import fpa_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [MODE_W-1:0] in_mode,
    input  wire logic [WORD_W-1:0] in_a,
    input  wire logic [WORD_W-1:0] in_b,
    output logic                   out_valid,
    output stage_t                 out_stage
);

    logic              s1_valid_reg;
    mode_t             s1_mode_reg;
    logic [WORD_W-1:0] s1_a_reg;
    logic [WORD_W-1:0] s1_b_reg;

    logic              s2_valid_reg;
    mode_t             s2_mode_reg;
    logic [PROD_W-1:0] s2_prod_reg;
    logic [WORD_W-1:0] s2_simple_reg;
    logic              s2_is_div_reg;
    logic              s2_dz_reg;
    div_t              s2_div_reg;

    logic [INT_W-1:0]  bi;
    logic [WORD_W-1:0] mul_b;
    logic [PROD_W-1:0] prod_next;
    logic [WORD_W-1:0] simple_next;
    logic              is_div_next;
    logic              dz_next;
    div_t              div_next;

    // stage one: register the transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_mode_reg <= mode_t'(in_mode);
            s1_a_reg    <= in_a;
            s1_b_reg    <= in_b;
        end
    end

    // multiplier operand: integer multiply takes the low half of b
    assign bi        = s1_b_reg[INT_W-1:0];
    assign mul_b     = (s1_mode_reg == MODE_MUL_INT) ? {{FRAC_BITS{1'b0}}, bi} : s1_b_reg;
    assign prod_next = {{WORD_W{1'b0}}, s1_a_reg} * {{WORD_W{1'b0}}, mul_b};

    // simple results and divider setup
    always_comb
    begin
        simple_next      = '0;
        is_div_next      = 1'b0;
        dz_next          = 1'b0;
        div_next.rem     = '0;
        div_next.quo     = '0;
        div_next.num     = '0;
        div_next.divisor = '0;
        case (s1_mode_reg)
            MODE_ADD:      simple_next = s1_a_reg + s1_b_reg;
            MODE_SUB:      simple_next = s1_a_reg - s1_b_reg;
            MODE_ADD_INT:  simple_next = s1_a_reg + {bi, {FRAC_BITS{1'b0}}};
            MODE_SUB_INT:  simple_next = s1_a_reg - {bi, {FRAC_BITS{1'b0}}};
            MODE_FROM_INT: simple_next = {s1_a_reg[INT_W-1:0], {FRAC_BITS{1'b0}}};
            MODE_TO_INT:   simple_next = {{INT_W{1'b0}}, s1_a_reg[WORD_W-1:FRAC_BITS]};
            MODE_DIV:
            begin
                is_div_next      = 1'b1;
                dz_next          = (s1_b_reg == '0);
                div_next.num     = {s1_a_reg, {FRAC_BITS{1'b0}}};
                div_next.divisor = s1_b_reg;
            end
            MODE_DIV_INT:
            begin
                is_div_next      = 1'b1;
                dz_next          = (bi == '0);
                div_next.num     = {{FRAC_BITS{1'b0}}, s1_a_reg};
                div_next.divisor = {{FRAC_BITS{1'b0}}, bi};
            end
            default:       simple_next = '0;
        endcase
    end

    // stage two: product and setup registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_mode_reg   <= s1_mode_reg;
            s2_prod_reg   <= prod_next;
            s2_simple_reg <= simple_next;
            s2_is_div_reg <= is_div_next;
            s2_dz_reg     <= dz_next;
            s2_div_reg    <= div_next;
        end
    end

    // pick the product slice for the multiply modes
    always_comb
    begin
        out_stage.div         = s2_div_reg;
        out_stage.side.is_div = s2_is_div_reg;
        out_stage.side.dz     = s2_dz_reg;
        case (s2_mode_reg)
            MODE_MUL:     out_stage.side.value = s2_prod_reg[FRAC_BITS +: WORD_W];
            MODE_MUL_INT: out_stage.side.value = s2_prod_reg[WORD_W-1:0];
            default:      out_stage.side.value = s2_simple_reg;
        endcase
    end

    assign out_valid = s2_valid_reg;

endmodule

`default_nettype wire

/* rtl/fpa_div_stage.sv */
// one restoring division step, one quotient bit per stage
`default_nettype none

module fpa_div_stage
    import fpa_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   en,
    input  wire logic   in_valid,
    input  wire stage_t in_stage,
    output logic        out_valid,
    output stage_t      out_stage
);

    logic              valid_reg;
    stage_t            stage_reg;
    stage_t            stage_next;
    logic [WORD_W:0]   trial;
    logic [WORD_W:0]   diff;
    logic              ge;

    // shift the next dividend bit into the remainder and try a subtract
    assign trial = {in_stage.div.rem, in_stage.div.num[DIVIDEND_W-1]};
    assign diff  = trial - {1'b0, in_stage.div.divisor};
    assign ge    = (trial >= {1'b0, in_stage.div.divisor});

    always_comb
    begin
        stage_next             = in_stage;
        stage_next.div.rem     = ge ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
        stage_next.div.num     = {in_stage.div.num[DIVIDEND_W-2:0], 1'b0};
        stage_next.div.quo     = {in_stage.div.quo[WORD_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stage_reg <= stage_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_stage = stage_reg;

endmodule

`default_nettype wire

/* rtl/fpa_out.sv */
// final result select and two-entry output buffer
`default_nettype none

`include "assert_macros.svh"

module fpa_out
    import fpa_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       pipe_valid,
    input  wire stage_t     pipe_stage,
    input  wire logic       ready,
    output logic            en,
    output logic            out_valid,
    output logic [WORD_W-1:0] out_result,
    output logic            out_dz
);

    logic              out_valid_reg;
    logic              out_valid_next;
    logic [WORD_W-1:0] out_result_reg;
    logic [WORD_W-1:0] out_result_next;
    logic              out_dz_reg;
    logic              out_dz_next;
    logic              skid_valid_reg;
    logic              skid_valid_next;
    logic [WORD_W-1:0] skid_result_reg;
    logic [WORD_W-1:0] skid_result_next;
    logic              skid_dz_reg;
    logic              skid_dz_next;
    logic [WORD_W-1:0] fin_result;
    logic              fin_dz;
    logic              take;

    // divide results replace the side value; zero divisor gives all ones
    always_comb
    begin
        fin_dz = pipe_stage.side.is_div & pipe_stage.side.dz;
        if (!pipe_stage.side.is_div)
        begin
            fin_result = pipe_stage.side.value;
        end
        else if (pipe_stage.side.dz)
        begin
            fin_result = ALL_ONES;
        end
        else
        begin
            fin_result = pipe_stage.div.quo;
        end
    end

    assign take = out_valid_reg & ready;
    assign en   = !skid_valid_reg;

    // output slot and skid slot
    always_comb
    begin
        out_valid_next   = out_valid_reg;
        out_result_next  = out_result_reg;
        out_dz_next      = out_dz_reg;
        skid_valid_next  = skid_valid_reg;
        skid_result_next = skid_result_reg;
        skid_dz_next     = skid_dz_reg;
        if (skid_valid_reg)
        begin
            if (take)
            begin
                out_result_next = skid_result_reg;
                out_dz_next     = skid_dz_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (!out_valid_reg || take)
        begin
            out_valid_next  = pipe_valid;
            out_result_next = fin_result;
            out_dz_next     = fin_dz;
        end
        else if (pipe_valid)
        begin
            skid_valid_next  = 1'b1;
            skid_result_next = fin_result;
            skid_dz_next     = fin_dz;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_result_reg  <= out_result_next;
        out_dz_reg      <= out_dz_next;
        skid_result_reg <= skid_result_next;
        skid_dz_reg     <= skid_dz_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_result = out_result_reg;
    assign out_dz     = out_dz_reg;

    // checks
    `FPA_ASSERT_IMPL(a_skid_needs_out, skid_valid_reg, out_valid_reg, "skid full with output empty")
    `FPA_ASSERT_IMPL(a_dz_all_ones, out_valid_reg && out_dz_reg, out_result_reg == ALL_ONES, "zero divisor result not all ones")
    `FPA_ASSERT_IMPL(a_skid_fill_on_stall, $rose(skid_valid_reg), $past(out_valid_reg && !ready), "skid filled without a stall")

endmodule

`default_nettype wire
